/* sv/double_ended_queue_macros.svh */
// assertion helpers shared by the checker
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// condition and consequence in the same cycle
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/deq_pkg.sv */
`default_nettype none

package deq_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;

  localparam logic [POS_W-1:0] POS_NONE = '1;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_UPDATE     = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

endpackage

`default_nettype wire

/* sv/deq_ram.sv */
`default_nettype none

module deq_ram
  import deq_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [AddrW-1:0]  raddr_a_i,
  input  wire logic [AddrW-1:0]  raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

/* sv/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit values in a ring buffer.
// Input channel: operation_i, value_i, new_value_i, qualified by in_valid_i;
// a transfer happens when in_valid_i is high and in_stall_o is low.
// Output channel: one result per input item, shown with out_valid_o and
// held until a cycle where out_stall_i is low.
// One item is worked on at a time; in_stall_o is high from the transfer
// until the result has been taken, and the next item can transfer in the
// cycle after the result transfer.
// Push, clear, unknown codes and a pop, search or update on an empty queue
// go S_EXEC, S_PEEK, S_LOAD, S_OUT; a pop has S_POP after S_EXEC.
// Search and update walk the entries one per cycle in S_SCAN through the
// ring address adder and the single compare, stopping at the first match
// from the front or after the last entry held.
// Front and back values are read back through the two memory read ports.
// Reset empties the queue (head and count go to zero) and leaves the entry
// memory as it is; no clearing pass is needed.
// While out_stall_i is high the result registers hold and no input is taken.
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic        [2:0]        operation_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic signed [DATA_W-1:0] new_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          ok_o,
  output logic signed      [DATA_W-1:0] popped_value_o,
  output logic signed      [POS_W-1:0]  position_o,
  output logic             [COUNT_W-1:0] count_o,
  output logic                          is_empty_o,
  output logic signed      [DATA_W-1:0] front_value_o,
  output logic signed      [DATA_W-1:0] back_value_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);
  localparam logic [SW-1:0] WRAP_C  = SW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_PEEK,
    S_LOAD,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [2:0]        op_q, op_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] nval_q, nval_d;
  logic [CW-1:0]     iss_q, iss_d;
  logic [CW-1:0]     cmp_q, cmp_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              ok_q, ok_d;
  logic [DATA_W-1:0] popped_q, popped_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0] front_q, front_d;
  logic [DATA_W-1:0] back_q, back_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [DATA_W-1:0] rd_a, rd_b;

  // shared ring address adder: head plus an offset, wrapped once
  logic [CW-1:0] off_sel;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] slot;

  logic          full, empty;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] head_m1, head_p1;

  assign slot_sum = SW'(head_q) + SW'(off_sel);
  assign slot     = (slot_sum >= WRAP_C) ? AW'(slot_sum - WRAP_C) : AW'(slot_sum);

  assign full     = (count_q == DEPTH_C);
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - CW'(1);
  assign head_m1  = (head_q == '0) ? LAST_C : head_q - AW'(1);
  assign head_p1  = (head_q == LAST_C) ? '0 : head_q + AW'(1);

  deq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    op_d      = op_q;
    val_d     = val_q;
    nval_d    = nval_q;
    iss_d     = iss_q;
    cmp_d     = cmp_q;
    pend_d    = pend_q;
    addr_d    = addr_q;
    ok_d      = ok_q;
    popped_d  = popped_q;
    pos_d     = pos_q;
    front_d   = front_q;
    back_d    = back_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = val_q;
    raddr_a   = head_q;
    raddr_b   = head_q;
    off_sel   = count_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          val_d    = value_i;
          nval_d   = new_value_i;
          ok_d     = 1'b0;
          popped_d = '0;
          pos_d    = POS_NONE;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_PEEK;
        case (op_q)
          OP_PUSH_FRONT: begin
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = head_m1;
              head_d    = head_m1;
              count_d   = count_q + CW'(1);
              ok_d      = 1'b1;
            end
          end
          OP_PUSH_BACK: begin
            off_sel = count_q;
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = slot;
              count_d   = count_q + CW'(1);
              ok_d      = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            raddr_a = head_q;
            if (!empty) begin
              state_d = S_POP;
            end
          end
          OP_POP_BACK: begin
            off_sel = count_m1;
            raddr_a = slot;
            if (!empty) begin
              state_d = S_POP;
            end
          end
          OP_SEARCH, OP_UPDATE: begin
            iss_d  = '0;
            pend_d = 1'b0;
            if (!empty) begin
              state_d = S_SCAN;
            end
          end
          OP_CLEAR: begin
            head_d  = '0;
            count_d = '0;
            ok_d    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        popped_d = rd_a;
        ok_d     = 1'b1;
        count_d  = count_m1;
        if (op_q == OP_POP_FRONT) begin
          head_d = head_p1;
        end
        state_d = S_PEEK;
      end
      S_SCAN: begin
        // issue one offset per cycle, compare the one issued last cycle
        off_sel = iss_q;
        raddr_a = slot;
        if (pend_q && (rd_a == val_q)) begin
          ok_d  = 1'b1;
          pos_d = (op_q == OP_SEARCH) ? POS_W'(cmp_q) : POS_NONE;
          if (op_q == OP_UPDATE) begin
            ram_we    = 1'b1;
            ram_waddr = addr_q;
            ram_wdata = nval_q;
          end
          state_d = S_PEEK;
        end else if (pend_q && (cmp_q == count_m1)) begin
          state_d = S_PEEK;
        end else begin
          pend_d = 1'b1;
          cmp_d  = iss_q;
          addr_d = slot;
          iss_d  = iss_q + CW'(1);
        end
      end
      S_PEEK: begin
        off_sel = count_m1;
        raddr_a = head_q;
        raddr_b = slot;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        front_d = empty ? '0 : rd_a;
        back_d  = empty ? '0 : rd_b;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      op_q     <= '0;
      val_q    <= '0;
      nval_q   <= '0;
      iss_q    <= '0;
      cmp_q    <= '0;
      pend_q   <= 1'b0;
      addr_q   <= '0;
      ok_q     <= 1'b0;
      popped_q <= '0;
      pos_q    <= POS_NONE;
      front_q  <= '0;
      back_q   <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      op_q     <= op_d;
      val_q    <= val_d;
      nval_q   <= nval_d;
      iss_q    <= iss_d;
      cmp_q    <= cmp_d;
      pend_q   <= pend_d;
      addr_q   <= addr_d;
      ok_q     <= ok_d;
      popped_q <= popped_d;
      pos_q    <= pos_d;
      front_q  <= front_d;
      back_q   <= back_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign ok_o           = ok_q;
  assign popped_value_o = popped_q;
  assign position_o     = pos_q;
  assign count_o        = COUNT_W'(count_q);
  assign is_empty_o     = empty;
  assign front_value_o  = front_q;
  assign back_value_o   = back_q;

endmodule

`default_nettype wire

/* sv/deq_checker.sv */
`default_nettype none

`include "double_ended_queue_macros.svh"

module deq_sva
  import deq_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic                     ok_o,
  input wire logic signed [POS_W-1:0]  position_o,
  input wire logic        [COUNT_W-1:0] count_o,
  input wire logic                     is_empty_o,
  input wire logic signed [DATA_W-1:0] front_value_o,
  input wire logic signed [DATA_W-1:0] back_value_o
);

  // a pending result blocks new input
  `DEQ_ASSERT_SAME(a_stall_while_result, out_valid_o, in_stall_o, "input taken with result pending")

  // an input transfer starts work, so the next cycle is busy
  `DEQ_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o, "not busy after transfer")

  // a result is held until it is taken
  `DEQ_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // an empty queue reports no entries and zero front and back
  `DEQ_ASSERT_SAME(a_empty_view, out_valid_o && is_empty_o, (count_o == '0) && (front_value_o == '0) && (back_value_o == '0), "empty queue shows data")

  // a found position always comes with ok
  `DEQ_ASSERT_SAME(a_pos_implies_ok, out_valid_o && (position_o != POS_NONE), ok_o, "position without ok")

endmodule

bind double_ended_queue deq_sva u_deq_checker (.*);

`default_nettype wire

/* tb/deq_checker.sv */
`timescale 1ns / 1ps

module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_o,
  input  wire logic [2:0]          operation_i,
  input  wire logic [DATA_W-1:0]   value_i,
  input  wire logic [DATA_W-1:0]   new_value_i,
  input  wire logic                out_valid_o,
  input  wire logic                out_stall_i,
  input  wire logic                ok_o,
  input  wire logic [DATA_W-1:0]   popped_value_o,
  input  wire logic [POS_W-1:0]    position_o,
  input  wire logic [COUNT_W-1:0]  count_o,
  input  wire logic                is_empty_o,
  input  wire logic [DATA_W-1:0]   front_value_o,
  input  wire logic [DATA_W-1:0]   back_value_o,
  output int                       fail_count,
  output int                       pending_count
);

  typedef struct packed {
    logic                ok;
    logic [DATA_W-1:0]   popped_value;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [DATA_W-1:0]   front_value;
    logic [DATA_W-1:0]   back_value;
  } deq_result_t;

  // shadow copy of the ring
  logic [DATA_W-1:0] shadow_store [DEPTH];
  int                ring_head = 0;
  int                ring_held = 0;

  deq_result_t expected_results [$];
  int          mismatches = 0;
  int          waiting_results = 0;

  assign fail_count    = mismatches;
  assign pending_count = waiting_results;

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
  end

  function automatic int ring_slot(int offset);
    return (ring_head + offset) % DEPTH;
  endfunction

  function automatic deq_result_t apply_deque_op(logic [2:0] op, logic [DATA_W-1:0] v,
                                                 logic [DATA_W-1:0] nv);
    deq_result_t r;
    int          hit;
    int          i;
    r = '0;
    r.position = POS_NONE;
    hit = -1;
    if (op == OP_SEARCH || op == OP_UPDATE) begin
      for (i = 0; i < ring_held; i++) begin
        if (hit < 0 && shadow_store[ring_slot(i)] == v) hit = i;
      end
    end
    case (op)
      OP_PUSH_FRONT: begin
        if (ring_held < DEPTH) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          shadow_store[ring_head] = v;
          ring_held++;
          r.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (ring_held < DEPTH) begin
          shadow_store[ring_slot(ring_held)] = v;
          ring_held++;
          r.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (ring_held > 0) begin
          r.popped_value = shadow_store[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_held--;
          r.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (ring_held > 0) begin
          r.popped_value = shadow_store[ring_slot(ring_held - 1)];
          ring_held--;
          r.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          r.position = hit[POS_W-1:0];
          r.ok = 1'b1;
        end
      end
      OP_UPDATE: begin
        // only the first match from the front is replaced
        if (hit >= 0) begin
          shadow_store[ring_slot(hit)] = nv;
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        ring_head = 0;
        ring_held = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = ring_held[COUNT_W-1:0];
    r.is_empty = (ring_held == 0);
    if (ring_held > 0) begin
      r.front_value = shadow_store[ring_head];
      r.back_value = shadow_store[ring_slot(ring_held - 1)];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (mismatches < 40) begin
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin : watch_channels
    deq_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (ok_o !== want.ok) report_mismatch("ok", DATA_W'(ok_o), DATA_W'(want.ok));
          if (popped_value_o !== want.popped_value)
            report_mismatch("popped_value", popped_value_o, want.popped_value);
          if (position_o !== want.position)
            report_mismatch("position", DATA_W'(position_o), DATA_W'(want.position));
          if (count_o !== want.count)
            report_mismatch("count", DATA_W'(count_o), DATA_W'(want.count));
          if (is_empty_o !== want.is_empty)
            report_mismatch("is_empty", DATA_W'(is_empty_o), DATA_W'(want.is_empty));
          if (front_value_o !== want.front_value)
            report_mismatch("front_value", front_value_o, want.front_value);
          if (back_value_o !== want.back_value)
            report_mismatch("back_value", back_value_o, want.back_value);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_deque_op(operation_i, value_i, new_value_i));
      end
      waiting_results <= expected_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  localparam int          DEPTH = 64;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          ROUNDS = 8;
  localparam int          FILL_ITEMS = 120;
  localparam int          DRAIN_ITEMS = 100;
  localparam logic [2:0]  OP_IGNORED = 3'd7;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic        [2:0]          operation_i = '0;
  logic signed [DATA_W-1:0]   value_i = '0;
  logic signed [DATA_W-1:0]   new_value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       ok_o;
  logic signed [DATA_W-1:0]   popped_value_o;
  logic signed [POS_W-1:0]    position_o;
  logic        [COUNT_W-1:0]  count_o;
  logic                       is_empty_o;
  logic signed [DATA_W-1:0]   front_value_o;
  logic signed [DATA_W-1:0]   back_value_o;

  int fail_count;
  int pending_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  double_ended_queue #(.DEPTH(DEPTH)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .new_value_i    (new_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .popped_value_o (popped_value_o),
    .position_o     (position_o),
    .count_o        (count_o),
    .is_empty_o     (is_empty_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o)
  );

  deq_checker #(.DEPTH(DEPTH)) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .new_value_i    (new_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .popped_value_o (popped_value_o),
    .position_o     (position_o),
    .count_o        (count_o),
    .is_empty_o     (is_empty_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL double_ended_queue");
      $finish;
    end
  end

  // holds the payload until the transfer happens
  task automatic send_item(logic [2:0] op, logic [DATA_W-1:0] v, logic [DATA_W-1:0] nv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    value_i <= v;
    new_value_i <= nv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // small pool so that searches and updates hit often
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = '0;
      3: v = '1;
      4, 5, 6: v = $urandom_range(11);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_op(bit filling);
    int roll;
    roll = $urandom_range(999);
    if (filling) begin
      if (roll < 400) return OP_PUSH_FRONT;
      if (roll < 800) return OP_PUSH_BACK;
      if (roll < 830) return OP_POP_FRONT;
      if (roll < 860) return OP_POP_BACK;
      if (roll < 920) return OP_SEARCH;
      if (roll < 990) return OP_UPDATE;
      if (roll < 995) return OP_CLEAR;
    end else begin
      if (roll < 50) return OP_PUSH_FRONT;
      if (roll < 100) return OP_PUSH_BACK;
      if (roll < 480) return OP_POP_FRONT;
      if (roll < 860) return OP_POP_BACK;
      if (roll < 920) return OP_SEARCH;
      if (roll < 975) return OP_UPDATE;
      if (roll < 985) return OP_CLEAR;
    end
    return OP_IGNORED;
  endfunction

  initial begin
    int round;
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue corner cases
    send_item(OP_POP_FRONT, 32'h1234_5678, 32'h0);
    send_item(OP_POP_BACK, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'h0, 32'h0);
    send_item(OP_UPDATE, 32'h0, 32'h1);
    // field extremes at both ends
    send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PUSH_BACK, 32'h8000_0000, 32'h0);
    send_item(OP_PUSH_FRONT, 32'h0, 32'h8000_0000);
    send_item(OP_PUSH_BACK, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 32'h8000_0000, 32'h0);
    send_item(OP_SEARCH, 32'h0000_3039, 32'h0);
    send_item(OP_UPDATE, 32'hFFFF_FFFF, 32'h5555_5555);
    send_item(OP_UPDATE, 32'hDEAD_BEEF, 32'hAAAA_AAAA);
    // duplicate: only the front-most match changes
    send_item(OP_PUSH_BACK, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_UPDATE, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    send_item(OP_SEARCH, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_POP_FRONT, 32'h0, 32'h0);
    send_item(OP_POP_BACK, 32'h0, 32'h0);
    send_item(OP_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 32'h0, 32'h0);
    send_item(OP_POP_BACK, 32'h0, 32'h0);
    send_item(OP_PUSH_BACK, 32'h5A5A_5A5A, 32'h0);
    send_item(OP_CLEAR, 32'h0, 32'h0);

    // fill toward full, then drain past empty, under each idling mix
    for (round = 0; round < ROUNDS; round++) begin
      case (round % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (n = 0; n < FILL_ITEMS; n++) send_item(pick_op(1'b1), pick_value(), $urandom);
      for (n = 0; n < DRAIN_ITEMS; n++) send_item(pick_op(1'b0), pick_value(), $urandom);
    end

    in_valid_i <= 1'b0;
    // let the count of the last transfer settle before waiting on it
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/deq_pkg.sv
sv/deq_ram.sv
sv/double_ended_queue.sv
sv/deq_checker.sv
tb/deq_checker.sv
tb/testbench.sv
